@@ hdl/csvtok_pkg.sv @@
// Shared types and character constants for the CSV row tokenizer.
// No dependencies; used by csvtok_step and csv_row_tokenizer_core.
package csvtok_pkg;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } kind_t;

    typedef struct packed {
        logic       quote_open;
        logic       quote_pending;
        logic       row_started;
        logic [7:0] column_index;
        logic       header_done;
        logic [7:0] header_columns;
    } tok_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [7:0] column;
        logic       in_header;
        logic [7:0] fields_in_row;
        logic       row_status;
    } tok_result_t;

endpackage

@@ hdl/csvtok_step.sv @@
// Next-state and result logic of the tokenizer for one input transfer.
// Depends on csvtok_pkg. Purely combinational; state is held by the caller.
module csvtok_step #(
    parameter int MAX_COLUMNS = 255
) (
    input  csvtok_pkg::tok_state_t  cur,
    input  logic                    mode,
    input  logic [7:0]              data_byte,
    output csvtok_pkg::tok_state_t  nxt,
    output logic [1:0]              count,
    output csvtok_pkg::tok_result_t res0,
    output csvtok_pkg::tok_result_t res1
);
    import csvtok_pkg::*;

    localparam int         CAP_INT = (MAX_COLUMNS - 1 < 254) ? MAX_COLUMNS - 1 : 254;
    localparam logic [7:0] COL_CAP = CAP_INT[7:0];

    logic       hdr;
    logic [7:0] fields;
    logic       mismatch;

    assign hdr      = !cur.header_done;
    assign fields   = cur.column_index + 8'd1;
    assign mismatch = cur.header_done && (fields != cur.header_columns);

    always_comb begin
        logic finish;
        finish = 1'b0;
        nxt    = cur;
        count  = 2'd0;
        res0   = '0;
        res1   = '0;
        res0.in_header = hdr;
        res0.column    = cur.column_index;

        if (mode) begin
            if (cur.row_started) begin
                finish = 1'b1;
            end else begin
                nxt.quote_open    = 1'b0;
                nxt.quote_pending = 1'b0;
            end
        end else if (cur.quote_pending && data_byte == CH_QUOTE) begin
            // doubled quote inside quotes: one literal quote, still open
            nxt.quote_pending = 1'b0;
            nxt.row_started   = 1'b1;
            res0.kind         = KIND_BYTE;
            res0.out_byte     = CH_QUOTE;
            count             = 2'd1;
        end else begin
            nxt.quote_pending = 1'b0;
            if (cur.quote_pending)
                nxt.quote_open = 1'b0;

            if (data_byte == CH_NEWLINE) begin
                if (cur.row_started)
                    finish = 1'b1;
                else
                    nxt.quote_open = 1'b0;   // empty line
            end else begin
                nxt.row_started = 1'b1;
                if (data_byte == CH_QUOTE) begin
                    if (nxt.quote_open)
                        nxt.quote_pending = 1'b1;
                    else
                        nxt.quote_open = 1'b1;
                end else if (data_byte == CH_COMMA && !nxt.quote_open) begin
                    res0.kind = KIND_FIELD_END;
                    count     = 2'd1;
                    if (cur.column_index < COL_CAP)
                        nxt.column_index = cur.column_index + 8'd1;
                end else begin
                    res0.kind     = KIND_BYTE;
                    res0.out_byte = data_byte;
                    count         = 2'd1;
                end
            end
        end

        if (finish) begin
            res0.kind          = KIND_FIELD_END;
            res0.out_byte      = '0;
            res1.kind          = KIND_ROW_END;
            res1.column        = cur.column_index;
            res1.in_header     = hdr;
            res1.fields_in_row = fields;
            res1.row_status    = mismatch;
            count              = 2'd2;
            if (!cur.header_done) begin
                nxt.header_columns = fields;
                nxt.header_done    = 1'b1;
            end
            nxt.column_index  = '0;
            nxt.row_started   = 1'b0;
            nxt.quote_open    = 1'b0;
            nxt.quote_pending = 1'b0;
        end
    end

endmodule

@@ hdl/csv_row_tokenizer_core.sv @@
// Top level of the CSV row tokenizer: stream ports, state and output stages.
// Depends on csvtok_pkg and csvtok_step.
//
// Takes one text byte per transfer and returns field bytes, field-end and
// row-end items. While m_tready is high, an item that produces one result
// or none lets the next byte be taken with no stall in between.
// A newline or end-of-stream that closes a row produces two results; the
// second waits in a hold register behind the output register, so the input
// stalls after it while the hold register drains. Sustained rate is
// therefore one byte per cycle while m_tready is high, plus a stall at each
// row end. The first non-empty line is the header; later row ends flag a
// field count that differs from the header's.
module csv_row_tokenizer_core #(
    parameter int MAX_COLUMNS = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [15:8] column, [16] in_header,
                                   // [24:17] fields_in_row, [25] row_status
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import csvtok_pkg::*;

    tok_state_t  state_reg, state_next;
    tok_result_t out_reg, hold_reg, res0, res1;
    logic        out_valid_reg, hold_valid_reg;
    logic [1:0]  count;
    logic        s_xfer;

    csvtok_step #(.MAX_COLUMNS(MAX_COLUMNS)) u_step (
        .cur       (state_reg),
        .mode      (s_tuser[0]),
        .data_byte (s_tdata),
        .nxt       (state_next),
        .count     (count),
        .res0      (res0),
        .res1      (res1)
    );

    assign s_tready = !hold_valid_reg && (!out_valid_reg || m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (s_xfer)
                state_reg <= state_next;
            if (hold_valid_reg && m_tready) begin
                hold_valid_reg <= 1'b0;
            end else if (s_xfer) begin
                out_valid_reg  <= (count != 2'd0);
                hold_valid_reg <= (count == 2'd2);
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (hold_valid_reg && m_tready) begin
            out_reg <= hold_reg;
        end else if (s_xfer) begin
            out_reg  <= res0;
            hold_reg <= res1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.row_status, out_reg.fields_in_row,
                       out_reg.in_header, out_reg.column, out_reg.out_byte};

endmodule
